// ===== rtl/ecmp_pkg.sv =====
package ecmp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_COLOR_MODE   = 2'd0;
  localparam logic [1:0] REG_ROW_WIDTH    = 2'd1;
  localparam logic [1:0] REG_INVERT_INPUT = 2'd2;

  localparam int CFG_DATA_WIDTH = 13;
  localparam int ROW_WIDTH_BITS = 13;

  // Display mode codes held in the colour mode register.
  localparam logic [2:0] MODE_BW   = 3'd0;
  localparam logic [2:0] MODE_BWR  = 3'd1;
  localparam logic [2:0] MODE_BWY  = 3'd2;
  localparam logic [2:0] MODE_BWYR = 3'd3;
  localparam logic [2:0] MODE_GRAY = 3'd4;

  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 13'd800;

  // Colour matching thresholds.
  localparam logic [7:0]        LIGHT_LEVEL = 8'd100;
  localparam logic [7:0]        DARK_LEVEL  = 8'd80;
  localparam logic signed [9:0] HUE_MARGIN  = 10'sd32;

  // One classified pixel on its way from the front end to the packer.
  // For the two-bit packed mode code holds the whole colour code, otherwise
  // code[0] goes to plane 0 and code[1] to plane 1.
  typedef struct packed {
    logic       pair_mode;
    logic [1:0] code;
    logic [2:0] col_low;
    logic       last;
  } ecmp_entry_t;

endpackage

// ===== rtl/epaper_color_match_packer.sv =====
// Colour matcher and bit-plane packer for e-paper panels.
//
// Pixel requests (red, green, blue) arrive on the pixel channel: a request
// is taken at a rising edge where pixel_valid is high and pixel_stall is low.
// Packed bytes leave on the byte channel under the same rule with byte_valid
// and byte_stall. Each byte request carries both plane bytes and row_end.
// Eight pixels make one byte in the one-bit modes, four in the packed
// two-bit mode, and the last byte of a row is padded with zero bits.
//
// One pixel is taken every clock while the queue has a free slot. The front
// end classifies a pixel and tracks its column in the cycle it is taken; the
// result goes into a two-entry queue, and the packer consumes one queue entry
// per clock unless the byte output is stalled. Completed bytes are registered.
// When the receiver stalls, the byte register holds its request; the packer
// stops, the queue fills, and pixel_stall rises once the queue is full.
//
// Configuration is written through cfg_write, cfg_index and cfg_data, one
// register per clock; the user must do so only while the block is idle, which
// the block does not enforce. Synchronous reset sets black and white mode, row
// width 800, no inversion, an empty queue and output, and column zero.
module epaper_color_match_packer
  import ecmp_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  output logic                      byte_valid,
  input  logic                      byte_stall,
  output logic [7:0]                plane0_byte,
  output logic [7:0]                plane1_byte,
  output logic                      row_end
);

  logic [2:0]                color_mode;
  logic [ROW_WIDTH_BITS-1:0] row_width;
  logic                      invert_input;

  logic        pixel_take;
  ecmp_entry_t front_entry;
  logic        queue_full;
  logic        queue_pop;
  logic        queue_valid;
  ecmp_entry_t queue_head;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= MODE_BW;
      row_width    <= ROW_WIDTH_RESET;
      invert_input <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLOR_MODE:   color_mode   <= cfg_data[2:0];
        REG_ROW_WIDTH:    row_width    <= cfg_data[ROW_WIDTH_BITS-1:0];
        REG_INVERT_INPUT: invert_input <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // The pixel side waits only when the queue has no free slot.
  assign pixel_stall = queue_full;
  assign pixel_take  = pixel_valid && !queue_full;

  ecmp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .color_mode   (color_mode),
    .row_width    (row_width),
    .invert_input (invert_input),
    .accept       (pixel_take),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .entry        (front_entry)
  );

  ecmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (pixel_take),
    .push_entry (front_entry),
    .full       (queue_full),
    .pop        (queue_pop),
    .not_empty  (queue_valid),
    .head       (queue_head)
  );

  ecmp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (queue_valid),
    .entry       (queue_head),
    .pop         (queue_pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .plane0_byte (plane0_byte),
    .plane1_byte (plane1_byte),
    .row_end     (row_end)
  );

endmodule

// ===== rtl/ecmp_front.sv =====
module ecmp_front
  import ecmp_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [2:0]                color_mode,
  input  logic [ROW_WIDTH_BITS-1:0] row_width,
  input  logic                      invert_input,
  input  logic                      accept,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  output ecmp_entry_t               entry
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = ((CW > ROW_WIDTH_BITS) ? CW : ROW_WIDTH_BITS) + 1;

  logic [CW-1:0] column_count;

  logic [LW-1:0] width_ext;
  logic [LW-1:0] width_max;
  logic [LW-1:0] width_eff;
  logic [LW-1:0] col_plus;
  logic          last;

  logic [7:0] r, g, b;
  logic [9:0] gray_sum;
  logic [9:0] lum_sum;
  logic [7:0] lum;
  logic signed [9:0] d_rb, d_rg, d_gb;
  logic [1:0] gray_code, red_code, yel_code, quad_code;
  logic       lum_light;

  assign width_ext = LW'(row_width);
  assign width_max = LW'(MAX_WIDTH);
  assign col_plus  = LW'(column_count) + LW'(1);

  always_comb begin
    if (width_ext == '0) begin
      width_eff = LW'(1);
    end else if (width_ext > width_max) begin
      width_eff = width_max;
    end else begin
      width_eff = width_ext;
    end
  end

  assign last = (col_plus >= width_eff);

  assign r = invert_input ? ~red   : red;
  assign g = invert_input ? ~green : green;
  assign b = invert_input ? ~blue  : blue;

  assign gray_sum  = {2'b00, b} + {2'b00, g} + {1'b0, r, 1'b0};
  assign gray_code = gray_sum[9:8];
  assign lum_sum   = {2'b00, b} + {2'b00, r} + {1'b0, g, 1'b0};
  assign lum       = lum_sum[9:2];
  assign lum_light = (lum >= LIGHT_LEVEL);

  assign d_rb = $signed({2'b00, r}) - $signed({2'b00, b});
  assign d_rg = $signed({2'b00, r}) - $signed({2'b00, g});
  assign d_gb = $signed({2'b00, g}) - $signed({2'b00, b});

  always_comb begin
    if (r > g && r > b) begin
      if (!lum_light && r < DARK_LEVEL) begin
        red_code = 2'd0;
      end else if (d_rb > HUE_MARGIN && d_rg > HUE_MARGIN) begin
        red_code = 2'd2;
      end else begin
        red_code = 2'd1;
      end
    end else begin
      red_code = {1'b0, lum_light};
    end

    if (r > b && g > b) begin
      if (!lum_light && r < DARK_LEVEL) begin
        yel_code = 2'd0;
      end else if (d_rb > HUE_MARGIN && d_gb > HUE_MARGIN) begin
        yel_code = 2'd2;
      end else begin
        yel_code = 2'd1;
      end
    end else begin
      yel_code = {1'b0, lum_light};
    end

    if (r > b || g > b) begin
      if (!lum_light && r < DARK_LEVEL && g < DARK_LEVEL) begin
        quad_code = 2'd0;
      end else if (d_rb > HUE_MARGIN && d_rg > HUE_MARGIN) begin
        quad_code = 2'd3;
      end else if (d_rb > HUE_MARGIN && d_gb > HUE_MARGIN) begin
        quad_code = 2'd2;
      end else begin
        quad_code = 2'd1;
      end
    end else begin
      quad_code = {1'b0, lum_light};
    end
  end

  always_comb begin
    entry.col_low   = column_count[2:0];
    entry.last      = last;
    entry.pair_mode = 1'b0;
    unique case (color_mode)
      MODE_BWR:  entry.code = red_code;
      MODE_BWY:  entry.code = yel_code;
      MODE_GRAY: entry.code = gray_code;
      MODE_BWYR: begin
        entry.code      = quad_code;
        entry.pair_mode = 1'b1;
      end
      default:   entry.code = {1'b0, gray_code[1]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
    end else if (accept) begin
      column_count <= last ? '0 : col_plus[CW-1:0];
    end
  end

endmodule

// ===== rtl/ecmp_queue.sv =====
module ecmp_queue
  import ecmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ecmp_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output ecmp_entry_t head
);

  ecmp_entry_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/ecmp_back.sv =====
module ecmp_back
  import ecmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        entry_valid,
  input  ecmp_entry_t entry,
  output logic        pop,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  plane0_byte,
  output logic [7:0]  plane1_byte,
  output logic        row_end
);

  logic [7:0] plane0_shift, plane0_shift_next;
  logic [7:0] plane1_shift, plane1_shift_next;
  logic [7:0] p0_in, p1_in;
  logic [2:0] pad;
  logic       full;
  logic       emit;

  assign pop = entry_valid && (!byte_valid || !byte_stall);

  always_comb begin
    if (entry.pair_mode) begin
      p0_in = {plane0_shift[5:0], entry.code};
      p1_in = 8'd0;
      full  = (entry.col_low[1:0] == 2'd3);
      pad   = {2'd3 - entry.col_low[1:0], 1'b0};
    end else begin
      p0_in = {plane0_shift[6:0], entry.code[0]};
      p1_in = {plane1_shift[6:0], entry.code[1]};
      full  = (entry.col_low == 3'd7);
      pad   = 3'd7 - entry.col_low;
    end
    emit = full || entry.last;
    if (full) begin
      plane0_shift_next = p0_in;
      plane1_shift_next = p1_in;
    end else begin
      plane0_shift_next = p0_in << pad;
      plane1_shift_next = p1_in << pad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane0_shift <= 8'd0;
      plane1_shift <= 8'd0;
      byte_valid   <= 1'b0;
    end else if (pop) begin
      if (emit) begin
        // A finished byte leaves the shift registers empty for the next one.
        plane0_shift <= 8'd0;
        plane1_shift <= 8'd0;
        byte_valid   <= 1'b1;
        plane0_byte  <= plane0_shift_next;
        plane1_byte  <= plane1_shift_next;
        row_end      <= entry.last;
      end else begin
        plane0_shift <= p0_in;
        plane1_shift <= p1_in;
        if (!byte_stall) begin
          byte_valid <= 1'b0;
        end
      end
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

endmodule
